// ===== design/q10_6_fixed_point_alu_unit_assert.svh =====
// Assertion macros shared by the Q10.6 arithmetic unit.
`ifndef Q10_6_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define Q10_6_FIXED_POINT_ALU_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define Q10_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition in one cycle that must bring another in the next cycle.
`define Q10_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/q10alu_pkg.sv =====
// Package with operation codes, constants and the pipeline stage type of the Q10.6 unit.
`default_nettype none

package q10alu_pkg;

	localparam int FRAC_BITS = 6;
	localparam int DIV_STEPS = 16 + FRAC_BITS;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_DIV   = 3'd3;
	localparam logic [2:0] OP_EQ    = 3'd4;
	localparam logic [2:0] OP_TOINT = 3'd5;

	typedef struct packed {
		logic [2:0]           op;
		logic [15:0]          res;
		logic                 ovf;
		logic                 eq;
		logic                 dbz;
		logic                 neg;
		logic [15:0]          dvsr;
		logic [15:0]          rem;
		logic [DIV_STEPS-1:0] work;
	} stage_t;

endpackage

`default_nettype wire

// ===== design/q10alu_front.sv =====
// Front stages: operand capture, multiply, add, subtract, compare, conversion and divider set-up.
`default_nettype none

module q10alu_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      vld_in,
	input  wire  [2:0]               op_in,
	input  wire  signed [15:0]       a_in,
	input  wire  signed [15:0]       b_in,
	output logic                     vld_out,
	output q10alu_pkg::stage_t       data_out
);

	logic               vld_s1;
	logic [2:0]         op_s1;
	logic signed [15:0] a_s1;
	logic signed [31:0] prod_s1;
	logic signed [16:0] sum_s1;
	logic signed [16:0] diff_s1;
	logic               eq_s1;
	logic               bzero_s1;
	logic               neg_s1;
	logic [15:0]        maga_s1;
	logic [15:0]        magb_s1;

	logic [15:0]        maga_c;
	logic [15:0]        magb_c;
	logic signed [31:0] mq_c;
	logic signed [16:0] ti_c;
	logic signed [16:0] aext_c;
	q10alu_pkg::stage_t nxt_c;

	logic               vld_s2;
	q10alu_pkg::stage_t data_s2;

	always_comb begin
		maga_c = a_in[15] ? 16'(-a_in) : 16'(a_in);
		magb_c = b_in[15] ? 16'(-b_in) : 16'(b_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= op_in;
			a_s1     <= a_in;
			prod_s1  <= 32'(a_in) * 32'(b_in);
			sum_s1   <= 17'(a_in) + 17'(b_in);
			diff_s1  <= 17'(a_in) - 17'(b_in);
			eq_s1    <= (a_in == b_in);
			bzero_s1 <= (b_in == 16'sd0);
			neg_s1   <= a_in[15] ^ b_in[15];
			maga_s1  <= maga_c;
			magb_s1  <= magb_c;
		end
	end

	always_comb begin
		mq_c   = (prod_s1 + (prod_s1[31] ? 32'sd63 : 32'sd0)) >>> q10alu_pkg::FRAC_BITS;
		aext_c = 17'(a_s1);
		ti_c   = (aext_c + (a_s1[15] ? 17'sd63 : 17'sd0)) >>> q10alu_pkg::FRAC_BITS;

		nxt_c      = '0;
		nxt_c.op   = op_s1;
		nxt_c.neg  = neg_s1;
		nxt_c.dvsr = magb_s1;
		nxt_c.work = {maga_s1, {q10alu_pkg::FRAC_BITS{1'b0}}};
		case (op_s1)
			q10alu_pkg::OP_ADD: begin
				nxt_c.res = sum_s1[15:0];
				nxt_c.ovf = sum_s1[16] ^ sum_s1[15];
			end
			q10alu_pkg::OP_SUB: begin
				nxt_c.res = diff_s1[15:0];
				nxt_c.ovf = diff_s1[16] ^ diff_s1[15];
			end
			q10alu_pkg::OP_MUL: begin
				nxt_c.res = mq_c[15:0];
				nxt_c.ovf = (mq_c[31:15] != {17{mq_c[15]}});
			end
			q10alu_pkg::OP_DIV: begin
				nxt_c.dbz = bzero_s1;
			end
			q10alu_pkg::OP_EQ: begin
				nxt_c.eq = eq_s1;
			end
			q10alu_pkg::OP_TOINT: begin
				nxt_c.res = ti_c[15:0];
			end
			default: begin
				nxt_c.res = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt_c;
		end
	end

	assign vld_out  = vld_s2;
	assign data_out = data_s2;

endmodule

`default_nettype wire

// ===== design/q10alu_div_step.sv =====
// One registered step of the restoring divider, giving one quotient bit.
`default_nettype none

module q10alu_div_step (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      vld_in,
	input  q10alu_pkg::stage_t       data_in,
	output logic                     vld_out,
	output q10alu_pkg::stage_t       data_out
);

	logic [16:0]        trial_c;
	logic [16:0]        diff_c;
	logic               ge_c;
	q10alu_pkg::stage_t nxt_c;

	logic               vld_s1;
	q10alu_pkg::stage_t data_s1;

	always_comb begin
		trial_c = {data_in.rem, data_in.work[q10alu_pkg::DIV_STEPS-1]};
		diff_c  = trial_c - {1'b0, data_in.dvsr};
		ge_c    = (trial_c >= {1'b0, data_in.dvsr});
		nxt_c      = data_in;
		nxt_c.rem  = ge_c ? diff_c[15:0] : trial_c[15:0];
		nxt_c.work = {data_in.work[q10alu_pkg::DIV_STEPS-2:0], ge_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt_c;
		end
	end

	assign vld_out  = vld_s1;
	assign data_out = data_s1;

endmodule

`default_nettype wire

// ===== design/q10_6_fixed_point_alu_unit.sv =====
// Top level of the pipelined Q10.6 fixed-point arithmetic unit.
//
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tuser: req_type[2:0]; tdata: operand_a[15:0], operand_b[31:16]
// m_*      out  tdata: result[15:0], is_equal[16], overflowed[17], divide_by_zero[18]
//
// One transaction is accepted per cycle unless the output stalls. Each one passes through the
// front stages, the divider (one quotient bit per stage over 22 stages) and the output register.
// Reset clears the valid bits of all stages; the pipeline is empty afterwards.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none

`include "q10_6_fixed_point_alu_unit_assert.svh"

module q10_6_fixed_point_alu_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // operand_a, operand_b
	input  wire  [2:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // result, is_equal, overflowed, divide_by_zero, zero fill
);

	logic                   adv;
	logic [q10alu_pkg::DIV_STEPS:0] stg_vld;
	q10alu_pkg::stage_t     stg [0:q10alu_pkg::DIV_STEPS];

	q10alu_pkg::stage_t     last_c;
	logic [22:0]            quo_c;
	logic [15:0]            res_c;
	logic                   ovf_c;

	logic                   vld_s25;
	logic [15:0]            res_s25;
	logic                   eq_s25;
	logic                   ovf_s25;
	logic                   dbz_s25;

	assign adv      = !vld_s25 || m_tready;
	assign s_tready = adv;

	q10alu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (s_tvalid),
		.op_in    (s_tuser),
		.a_in     (s_tdata[15:0]),
		.b_in     (s_tdata[31:16]),
		.vld_out  (stg_vld[0]),
		.data_out (stg[0])
	);

	for (genvar i = 0; i < q10alu_pkg::DIV_STEPS; i++) begin : g_div
		q10alu_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (stg_vld[i]),
			.data_in  (stg[i]),
			.vld_out  (stg_vld[i+1]),
			.data_out (stg[i+1])
		);
	end

	always_comb begin
		last_c = stg[q10alu_pkg::DIV_STEPS];
		quo_c  = last_c.neg ? 23'(-{1'b0, last_c.work}) : {1'b0, last_c.work};
		res_c  = last_c.res;
		ovf_c  = last_c.ovf;
		if (last_c.op == q10alu_pkg::OP_DIV && !last_c.dbz) begin
			res_c = quo_c[15:0];
			ovf_c = (quo_c[22:15] != {8{quo_c[15]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s25 <= 1'b0;
		end else if (adv) begin
			vld_s25 <= stg_vld[q10alu_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s25 <= res_c;
			eq_s25  <= last_c.eq;
			ovf_s25 <= ovf_c;
			dbz_s25 <= last_c.dbz;
		end
	end

	assign m_tvalid = vld_s25;
	assign m_tdata  = {5'd0, dbz_s25, ovf_s25, eq_s25, res_s25};

	`Q10_ASSERT_ALWAYS(a_flags_excl, !m_tvalid || $onehot0(m_tdata[18:16]), "Flags overlap.")
	`Q10_ASSERT_ALWAYS(a_dbz_zero, !(m_tvalid && dbz_s25) || (res_s25 == 16'd0), "Bad zero divide.")
	`Q10_ASSERT_ALWAYS(a_eq_zero, !(m_tvalid && eq_s25) || (res_s25 == 16'd0), "Bad equal result.")
	`Q10_ASSERT_NEXT(a_enter, s_tvalid && s_tready, u_front.vld_s1, "Transaction lost at entry.")

endmodule

`default_nettype wire

// ===== tb/sv/tb_q10_6_fixed_point_alu_unit.sv =====
// Testbench for the Q10.6 unit: a directed table and random operations checked by a predictor.
`timescale 1ns / 1ps

module tb_q10_6_fixed_point_alu_unit;

	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;
	localparam int Q_SCALE = 1 << q10alu_pkg::FRAC_BITS;
	localparam int RANDOM_ITEMS = 1600;
	localparam int MAX_IDLE = 13;
	localparam int TAIL_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTED = 10;

	typedef struct packed {
		logic        dbz;
		logic        ovf;
		logic        eq;
		logic [15:0] value;
	} alu_result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] a;
		logic [15:0] b;
		logic        given;
		alu_result_t want;
	} directed_row_t;

	localparam int NUM_DIRECTED = 25;
	localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
		'{q10alu_pkg::OP_ADD,   16'h7fff, 16'h0001, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h8000}},
		'{q10alu_pkg::OP_ADD,   16'h8000, 16'h8000, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_SUB,   16'h8000, 16'h0001, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h7fff}},
		'{q10alu_pkg::OP_SUB,   16'h0000, 16'h8000, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h8000}},
		'{q10alu_pkg::OP_SUB,   16'h7fff, 16'h7fff, 1'b0, '0},
		'{q10alu_pkg::OP_MUL,   16'h7fff, 16'h7fff, 1'b0, '0},
		'{q10alu_pkg::OP_MUL,   16'h8000, 16'h8000, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_MUL,   16'h0040, 16'h0040, 1'b0, '0},
		'{q10alu_pkg::OP_MUL,   16'hffff, 16'h0001, 1'b0, '0},
		'{q10alu_pkg::OP_MUL,   16'h8000, 16'h0040, 1'b0, '0},
		'{q10alu_pkg::OP_DIV,   16'h0064, 16'h0000, 1'b1, '{1'b1, 1'b0, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_DIV,   16'h8000, 16'h0000, 1'b1, '{1'b1, 1'b0, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_DIV,   16'h8000, 16'h0001, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_DIV,   16'h8000, 16'hffff, 1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_DIV,   16'h0040, 16'h0040, 1'b0, '0},
		'{q10alu_pkg::OP_DIV,   16'hfff9, 16'h0002, 1'b0, '0},
		'{q10alu_pkg::OP_DIV,   16'h7fff, 16'h8000, 1'b0, '0},
		'{q10alu_pkg::OP_EQ,    16'h0005, 16'h0005, 1'b1, '{1'b0, 1'b0, 1'b1, 16'h0000}},
		'{q10alu_pkg::OP_EQ,    16'h0005, 16'h0006, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
		'{q10alu_pkg::OP_EQ,    16'h8000, 16'h8000, 1'b1, '{1'b0, 1'b0, 1'b1, 16'h0000}},
		'{q10alu_pkg::OP_TOINT, 16'h7fff, 16'h1234, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h01ff}},
		'{q10alu_pkg::OP_TOINT, 16'h8000, 16'h0000, 1'b1, '{1'b0, 1'b0, 1'b0, 16'hfe00}},
		'{q10alu_pkg::OP_TOINT, 16'hffbf, 16'hffff, 1'b0, '0},
		'{OP_RSVD6,             16'h7fff, 16'h7fff, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}},
		'{OP_RSVD7,             16'h8000, 16'hffff, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	alu_result_t pending_results [$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;

	q10_6_fixed_point_alu_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic alu_result_t q10_compute(input logic [2:0] op,
			input logic signed [15:0] a, input logic signed [15:0] b);
		alu_result_t r;
		int          exact;
		bit          arith;
		r = '0;
		exact = 0;
		arith = 1'b1;
		case (op)
			q10alu_pkg::OP_ADD: exact = int'(a) + int'(b);
			q10alu_pkg::OP_SUB: exact = int'(a) - int'(b);
			q10alu_pkg::OP_MUL: exact = (int'(a) * int'(b)) / Q_SCALE;
			q10alu_pkg::OP_DIV: begin
				if (b == 16'sd0) begin
					r.dbz = 1'b1;
					arith = 1'b0;
				end else begin
					exact = (int'(a) * Q_SCALE) / int'(b);
				end
			end
			q10alu_pkg::OP_EQ: begin
				r.eq = (a == b);
				arith = 1'b0;
			end
			q10alu_pkg::OP_TOINT: exact = int'(a) / Q_SCALE;
			default: arith = 1'b0;
		endcase
		if (arith) begin
			r.value = exact[15:0];
			r.ovf = (exact < -32768) || (exact > 32767);
		end
		return r;
	endfunction

	function automatic logic [15:0] pick_operand();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h7fff;
			1: v = 16'h8000;
			2: v = $urandom_range(0, 1) ? 16'h0001 : 16'hffff;
			3, 4: v = 16'($urandom_range(0, 1023) - 512);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic log_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("Mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic issue_operation(input logic [2:0] op, input logic [15:0] a,
			input logic [15:0] b, input alu_result_t want);
		int unsigned gap;
		if ($urandom_range(0, 99) < 3)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {b, a};
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(want);
	endtask

	initial begin : stimulus
		directed_row_t row;
		logic [2:0]    op;
		logic [15:0]   a;
		logic [15:0]   b;
		int unsigned   r;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			row = DIRECTED[i];
			issue_operation(row.op, row.a, row.b,
				row.given ? row.want : q10_compute(row.op, row.a, row.b));
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 94)
				op = 3'($urandom_range(q10alu_pkg::OP_ADD, q10alu_pkg::OP_TOINT));
			else
				op = r[0] ? OP_RSVD6 : OP_RSVD7;
			a = pick_operand();
			b = pick_operand();
			if (op == q10alu_pkg::OP_DIV && $urandom_range(0, 9) == 0)
				b = 16'h0000;
			if (op == q10alu_pkg::OP_EQ && $urandom_range(0, 2) == 0)
				b = a;
			issue_operation(op, a, b, q10_compute(op, a, b));
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 99) < 3)
				rx_quiet = !rx_quiet;
			stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		alu_result_t got;
		alu_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[18], m_tdata[17], m_tdata[16], m_tdata[15:0]};
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("unexpected transaction, result %h eq %b ovf %b dbz %b",
					got.value, got.eq, got.ovf, got.dbz));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					log_mismatch($sformatf({"result %h/%h eq %b/%b ovf %b/%b dbz %b/%b",
						" (expected/actual)"}, want.value, got.value, want.eq, got.eq,
						want.ovf, got.ovf, want.dbz, got.dbz));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== q10_6_fixed_point_alu_unit.f =====
+incdir+design
design/q10alu_pkg.sv
design/q10alu_front.sv
design/q10alu_div_step.sv
design/q10_6_fixed_point_alu_unit.sv
tb/sv/tb_q10_6_fixed_point_alu_unit.sv
